>>> design/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared types and constants of the wheel speed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfr_pkg;

  localparam int unsigned SpeedW    = 16;
  localparam int unsigned DutyW     = 15;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned FrameBufN = 6;
  localparam int unsigned CountW    = 3;

  localparam logic [7:0]        FrameHeader = 8'hAA;
  localparam logic [7:0]        FrameTail   = 8'h55;
  localparam logic [CountW-1:0] FrameLast   = 3'd6;

  localparam logic [TicksW-1:0] TimeoutReset = 16'd500;
  localparam logic [DutyW-1:0]  LimitReset   = 15'd1000;
  localparam logic [3:0]        DirForward   = 4'b0011;
  localparam logic [3:0]        DirReverse   = 4'b0000;

  localparam logic [CfgIdxW-1:0] CfgTimeoutMs  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSpeedLimit = 2'd1;

  localparam logic FuncByte = 1'b0;
  localparam logic FuncTick = 1'b1;

  typedef enum logic [1:0] {
    StatusSet      = 2'd0,
    StatusChecksum = 2'd1,
    StatusFraming  = 2'd2,
    StatusTimeout  = 2'd3
  } status_e;

  typedef struct packed {
    status_e                  status;
    logic [DutyW-1:0]         left_duty;
    logic [DutyW-1:0]         right_duty;
    logic [3:0]               dir_pins;
    logic signed [SpeedW-1:0] left_vel;
    logic signed [SpeedW-1:0] right_vel;
  } result_t;

endpackage

`default_nettype wire

>>> design/wsfr_if.sv
// ----------------------------------------------------------------------------
// wsfr channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface wsfr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            status;
  logic [wsfr_pkg::DutyW-1:0]            left_duty;
  logic [wsfr_pkg::DutyW-1:0]            right_duty;
  logic [3:0]                            dir_pins;
  logic signed [wsfr_pkg::SpeedW-1:0]    left_vel;
  logic signed [wsfr_pkg::SpeedW-1:0]    right_vel;

  modport source (output valid, output status, output left_duty, output right_duty,
                  output dir_pins, output left_vel, output right_vel, input ready);
  modport sink   (input valid, input status, input left_duty, input right_duty,
                  input dir_pins, input left_vel, input right_vel, output ready);
endinterface

interface wsfr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wsfr_pkg::CfgIdxW-1:0]    index;
  logic [wsfr_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/wsfr_clamp.sv
// ----------------------------------------------------------------------------
// wsfr_clamp
// Clamps a signed 16-bit wheel speed to plus or minus an unsigned limit.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfr_clamp (
  input  wire logic signed [wsfr_pkg::SpeedW-1:0] raw_i,
  input  wire logic        [wsfr_pkg::DutyW-1:0]  limit_i,
  output logic signed      [wsfr_pkg::SpeedW-1:0] speed_o
);

  logic signed [wsfr_pkg::SpeedW:0] raw_ext;
  logic signed [wsfr_pkg::SpeedW:0] lim_pos;
  logic signed [wsfr_pkg::SpeedW:0] lim_neg;
  logic signed [wsfr_pkg::SpeedW:0] clamped;

  assign raw_ext = {raw_i[wsfr_pkg::SpeedW-1], raw_i};
  assign lim_pos = $signed({2'b00, limit_i});
  assign lim_neg = -lim_pos;

  // Even -32768 ends up within 15 bits of magnitude, since the limit does.
  always_comb begin
    if (raw_ext > lim_pos) begin
      clamped = lim_pos;
    end else if (raw_ext < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = raw_ext;
    end
  end

  assign speed_o = clamped[wsfr_pkg::SpeedW-1:0];

endmodule

`default_nettype wire

>>> design/wheel_speed_frame_receiver.sv
// ----------------------------------------------------------------------------
// wheel_speed_frame_receiver
// Serial command frame decoder with speed clamp and command timeout.
// ----------------------------------------------------------------------------
// Each input item is either a received byte or a millisecond tick, and the
// block takes one item in every clock cycle unless input stalls. Bytes are
// grouped strictly in sevens from reset; the seventh byte of a frame and a
// tick that stops the motors each give one result item, which goes to the
// output register, or to the one skid entry while that register holds a
// result not yet taken. Input stalls only while both hold results not yet
// taken. Register writes are accepted in any cycle and should be made while idle.
`default_nettype none

module wheel_speed_frame_receiver (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  wsfr_in_if.sink     in_i,
  wsfr_out_if.source  out_o,
  wsfr_cfg_if.sink    cfg_i
);

  localparam int unsigned SpeedW = wsfr_pkg::SpeedW;
  localparam int unsigned DutyW  = wsfr_pkg::DutyW;
  localparam int unsigned TicksW = wsfr_pkg::TicksW;
  localparam int unsigned CountW = wsfr_pkg::CountW;

  // Configuration.
  logic [TicksW-1:0] timeout_q;
  logic [DutyW-1:0]  limit_q;
  logic              cfg_acc;

  // Frame and motor state.
  logic [CountW-1:0]       byte_cnt_q, byte_cnt_d;
  logic [7:0]              frame_q [wsfr_pkg::FrameBufN];
  logic [TicksW-1:0]       ticks_q, ticks_d;
  logic signed [SpeedW-1:0] left_q, left_d;
  logic signed [SpeedW-1:0] right_q, right_d;

  // Result path.
  wsfr_pkg::result_t out_q, skid_q, res_new;
  logic              out_v_q, skid_v_q;
  logic              in_acc, pop, push;

  logic [TicksW-1:0]        ticks_inc;
  logic                     timeout_hit;
  logic                     frame_end;
  logic [7:0]               sum;
  logic signed [SpeedW-1:0] left_clamp, right_clamp;
  wsfr_pkg::status_e        status;
  logic [SpeedW-1:0]        left_abs, right_abs;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= wsfr_pkg::TimeoutReset;
      limit_q   <= wsfr_pkg::LimitReset;
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        wsfr_pkg::CfgTimeoutMs:  timeout_q <= cfg_i.data;
        wsfr_pkg::CfgSpeedLimit: limit_q   <= cfg_i.data[DutyW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !skid_v_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign pop        = out_v_q && out_o.ready;

  assign ticks_inc   = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
  assign timeout_hit = (ticks_inc > timeout_q) && ((left_q != '0) || (right_q != '0));
  assign frame_end   = (byte_cnt_q == wsfr_pkg::FrameLast);
  assign sum         = frame_q[1] + frame_q[2] + frame_q[3] + frame_q[4];

  wsfr_clamp u_clamp_left (
    .raw_i   ($signed({frame_q[2], frame_q[1]})),
    .limit_i (limit_q),
    .speed_o (left_clamp)
  );

  wsfr_clamp u_clamp_right (
    .raw_i   ($signed({frame_q[4], frame_q[3]})),
    .limit_i (limit_q),
    .speed_o (right_clamp)
  );

  always_comb begin
    byte_cnt_d = byte_cnt_q;
    ticks_d    = ticks_q;
    left_d     = left_q;
    right_d    = right_q;
    status     = wsfr_pkg::StatusSet;
    push       = 1'b0;
    if (in_acc) begin
      if (in_i.func == wsfr_pkg::FuncTick) begin
        ticks_d = ticks_inc;
        if (timeout_hit) begin
          left_d  = '0;
          right_d = '0;
          status  = wsfr_pkg::StatusTimeout;
          push    = 1'b1;
        end
      end else if (!frame_end) begin
        byte_cnt_d = byte_cnt_q + 1'b1;
      end else begin
        byte_cnt_d = '0;
        push       = 1'b1;
        if (frame_q[0] != wsfr_pkg::FrameHeader || in_i.rx_byte != wsfr_pkg::FrameTail) begin
          status = wsfr_pkg::StatusFraming;
        end else if (sum != frame_q[5]) begin
          status = wsfr_pkg::StatusChecksum;
        end else begin
          left_d  = left_clamp;
          right_d = right_clamp;
          ticks_d = '0;
        end
      end
    end
  end

  // The result always reports the speeds in force after this item.
  assign left_abs  = left_d[SpeedW-1]  ? (SpeedW'(0) - left_d)  : left_d;
  assign right_abs = right_d[SpeedW-1] ? (SpeedW'(0) - right_d) : right_d;

  always_comb begin
    res_new.status     = status;
    res_new.left_duty  = left_abs[DutyW-1:0];
    res_new.right_duty = right_abs[DutyW-1:0];
    res_new.dir_pins   = left_d[SpeedW-1] ? wsfr_pkg::DirReverse : wsfr_pkg::DirForward;
    res_new.left_vel   = left_d;
    res_new.right_vel  = right_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      ticks_q    <= '0;
      left_q     <= '0;
      right_q    <= '0;
    end else begin
      byte_cnt_q <= byte_cnt_d;
      ticks_q    <= ticks_d;
      left_q     <= left_d;
      right_q    <= right_d;
    end
  end

  // Frame bytes are always written before the seventh byte reads them.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.func == wsfr_pkg::FuncByte && !frame_end) begin
      frame_q[byte_cnt_q] <= in_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q) begin
      out_v_q <= push;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      out_q <= skid_v_q ? skid_q : res_new;
    end
    if (out_v_q && !pop && push) begin
      skid_q <= res_new;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.status     = out_q.status;
  assign out_o.left_duty  = out_q.left_duty;
  assign out_o.right_duty = out_q.right_duty;
  assign out_o.dir_pins   = out_q.dir_pins;
  assign out_o.left_vel   = out_q.left_vel;
  assign out_o.right_vel  = out_q.right_vel;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds a result while the output register is empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_cnt_q <= wsfr_pkg::FrameLast)
    else $error("byte count ran past the end of a frame");

  a_timeout_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.func == wsfr_pkg::FuncTick && timeout_hit)
      |=> (left_q == '0 && right_q == '0))
    else $error("timeout stop left a speed nonzero");

  a_good_frame_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && status == wsfr_pkg::StatusSet) |=> (ticks_q == '0))
    else $error("good frame did not restart the tick count");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_v_q)
    else $error("result item was dropped");
`endif

endmodule

`default_nettype wire
